FILE: hdl/sharpen_3x3_rgb_stream_defines.svh
// Assertion macros shared by the sharpen filter RTL.
`ifndef SHARPEN_3X3_RGB_STREAM_DEFINES_SVH
`define SHARPEN_3X3_RGB_STREAM_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: whenever a holds, c must hold too.
`define SHP_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication: whenever a holds, c must hold in the next cycle.
`define SHP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("assertion failed");

`else

`define SHP_ASSERT_IMPLY(label, clk, rst_n, a, c)
`define SHP_ASSERT_NEXT(label, clk, rst_n, a, c)

`endif

`endif

FILE: hdl/shp_pkg.sv
// Types and constants of the 3x3 RGB sharpen filter.
package shp_pkg;

    localparam int SHP_MAX_COLS = 512;
    localparam int SHP_MAX_ROWS = 1024;

    // Configuration register indexes
    localparam logic [1:0] REG_STRENGTH_K   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam int CFG_DATA_W = 11;

    localparam logic [3:0]  STRENGTH_RST = 4'd4;
    localparam logic [9:0]  WIDTH_RST    = 10'd320;
    localparam logic [10:0] HEIGHT_RST   = 11'd240;

    // Smallest frame side the window logic supports
    localparam int SIZE_MIN = 3;

    // Result slots of one input: (row-1,col-1), (row-1,col), (row,col-1), (row,col)
    localparam logic [1:0] SLOT_INNER  = 2'd0;
    localparam logic [1:0] SLOT_RIGHT  = 2'd1;
    localparam logic [1:0] SLOT_BOTTOM = 2'd2;
    localparam logic [1:0] SLOT_CORNER = 2'd3;

    typedef logic [23:0] t_pix;              // {blue, green, red}
    typedef t_pix [2:0][2:0] t_win;          // [column: left, mid, right][row: up, mid, cur]

    typedef struct packed {
        logic [3:0] mask;                    // one bit per result slot
        logic       border0;                 // inner slot passes through
        logic [9:0] row_a;                   // row - 1
        logic [9:0] row_b;                   // row
        logic [8:0] col_a;                   // col - 1
        logic [8:0] col_b;                   // col
    } t_meta;

    typedef struct packed {
        t_meta          meta;
        t_pix [3:0]     pix;
    } t_bundle;

endpackage

FILE: hdl/shp_kernel.sv
// Per-channel sharpen arithmetic: registered products, then combine and clamp.
module shp_kernel
    import shp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [3:0] i_k,
    input  t_win       i_win,
    output t_pix       o_pix
);

    logic [12:0] r_pos [3];
    logic [14:0] r_neg [3];

    logic [12:0] n_pos [3];
    logic [14:0] n_neg [3];

    always_comb begin
        logic [10:0] sum;
        logic [4:0]  kp1;
        kp1 = {1'b0, i_k} + 5'd1;
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    if (!(c == 1 && r == 1)) begin
                        sum = sum + {3'b0, i_win[c][r][8*ch +: 8]};
                    end
                end
            end
            n_pos[ch] = 13'(kp1 * i_win[1][1][8*ch +: 8]);
            n_neg[ch] = 15'(i_k * sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_pos[ch] <= n_pos[ch];
                r_neg[ch] <= n_neg[ch];
            end
        end
    end

    // v = 8*(K+1)*centre - K*sum; floor(v/8) clamped to 0..255
    always_comb begin
        logic signed [16:0] v;
        logic [12:0]        q;
        for (int ch = 0; ch < 3; ch++) begin
            v = $signed({1'b0, r_pos[ch], 3'b000}) - $signed({2'b00, r_neg[ch]});
            q = v[15:3];
            if (v[16]) begin
                o_pix[8*ch +: 8] = 8'd0;
            end else if (q > 13'd255) begin
                o_pix[8*ch +: 8] = 8'd255;
            end else begin
                o_pix[8*ch +: 8] = q[7:0];
            end
        end
    end

endmodule

FILE: hdl/shp_drain.sv
// Sequencer: a bundle of up to four results, emitted one a cycle unless stalled.
module shp_drain
    import shp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_bundle    i_bundle,
    output logic       o_take,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [9:0] o_out_row,
    output logic [8:0] o_out_col,
    output logic       o_is_border,
    output logic       o_last_of_run,
    output logic       o_frame_done
);

    t_bundle    r_bnd;
    logic [3:0] r_rem;
    logic       r_out_valid;
    t_pix       r_out_pix;
    logic [9:0] r_out_row;
    logic [8:0] r_out_col;
    logic       r_out_border;
    logic       r_out_last;
    logic       r_out_done;

    logic       out_free;
    logic       pop;
    logic [1:0] sel;
    logic [3:0] n_rem;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_rem != 4'd0) && out_free;

    always_comb begin
        if (r_rem[0]) begin
            sel = SLOT_INNER;
        end else if (r_rem[1]) begin
            sel = SLOT_RIGHT;
        end else if (r_rem[2]) begin
            sel = SLOT_BOTTOM;
        end else begin
            sel = SLOT_CORNER;
        end
        n_rem      = r_rem;
        n_rem[sel] = 1'b0;
    end

    // Take a new bundle once the current one is empty or gives its last result now
    assign o_take = (r_rem == 4'd0) || (pop && n_rem == 4'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && o_take) begin
                r_rem <= i_bundle.meta.mask;
            end else if (pop) begin
                r_rem <= n_rem;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_take) begin
            r_bnd <= i_bundle;
        end
        if (pop) begin
            r_out_pix    <= r_bnd.pix[sel];
            r_out_row    <= sel[1] ? r_bnd.meta.row_b : r_bnd.meta.row_a;
            r_out_col    <= sel[0] ? r_bnd.meta.col_b : r_bnd.meta.col_a;
            r_out_border <= (sel == SLOT_INNER) ? r_bnd.meta.border0 : 1'b1;
            r_out_last   <= (n_rem == 4'd0);
            r_out_done   <= (sel == SLOT_CORNER);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_out     = r_out_pix[7:0];
    assign o_green_out   = r_out_pix[15:8];
    assign o_blue_out    = r_out_pix[23:16];
    assign o_out_row     = r_out_row;
    assign o_out_col     = r_out_col;
    assign o_is_border   = r_out_border;
    assign o_last_of_run = r_out_last;
    assign o_frame_done  = r_out_done;

endmodule

FILE: hdl/sharpen_3x3_rgb_stream.sv
// Throughput: one pixel per cycle unless stalled. Past row zero, an input in the last
// column, or in the last row past column zero, causes 2 to 4 results; the sequencer emits
// one a cycle unless the output stalls, holding input back meanwhile. The line memory is
// one read and one write port, read at accept, written when the item leaves s1. Reset
// (synchronous, active low): counters, window and stage valids clear, registers take
// strength 4, width 320, height 240; the line memory is not cleared.
`include "sharpen_3x3_rgb_stream_defines.svh"

module sharpen_3x3_rgb_stream
    import shp_pkg::*;
#(
    parameter int MAX_COLS = SHP_MAX_COLS,
    parameter int MAX_ROWS = SHP_MAX_ROWS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic [9:0]            o_out_row,
    output logic [8:0]            o_out_col,
    output logic                  o_is_border,
    output logic                  o_last_of_run,
    output logic                  o_frame_done
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int EWW0 = $clog2(MAX_COLS + 1);
    localparam int EHW0 = $clog2(MAX_ROWS + 1);
    localparam int EWW  = (EWW0 > 10) ? EWW0 : 10;
    localparam int EHW  = (EHW0 > 11) ? EHW0 : 11;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [3:0]  r_strength_k;
    logic [9:0]  r_image_width;
    logic [10:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength_k   <= STRENGTH_RST;
            r_image_width  <= WIDTH_RST;
            r_image_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_STRENGTH_K:   r_strength_k   <= i_cfg_data[3:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[9:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the frame size to what the window and the line memory support
    logic [EWW-1:0] w_ext, w_eff;
    logic [EHW-1:0] h_ext, h_eff;

    always_comb begin
        w_ext = EWW'(r_image_width);
        h_ext = EHW'(r_image_height);
        if (w_ext < EWW'(SIZE_MIN)) begin
            w_eff = EWW'(SIZE_MIN);
        end else if (w_ext > EWW'(MAX_COLS)) begin
            w_eff = EWW'(MAX_COLS);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext < EHW'(SIZE_MIN)) begin
            h_eff = EHW'(SIZE_MIN);
        end else if (h_ext > EHW'(MAX_ROWS)) begin
            h_eff = EHW'(MAX_ROWS);
        end else begin
            h_eff = h_ext;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: s1 (memory read in flight), s2 (window ready),
    // s3 (products ready), then the result sequencer.
    // ---------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_s3_valid;
    logic adv1, adv2, adv3;
    logic drain_take;
    logic in_accept;

    assign adv3       = r_s3_valid && drain_take;
    assign adv2       = r_s2_valid && (!r_s3_valid || adv3);
    assign adv1       = r_s1_valid && (!r_s2_valid || adv2);
    assign o_in_stall = r_s1_valid && !adv1;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------------------------------------------------------
    // Position counters and per-input result plan
    // ---------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          last_col, last_row, interior;
    t_meta         n_meta;

    always_comb begin
        logic [EWW-1:0] col_ext;
        logic [EHW-1:0] row_ext;
        logic           row_ge1, col_ge1;
        col_ext  = EWW'(r_col);
        row_ext  = EHW'(r_row);
        last_col = col_ext >= (w_eff - EWW'(1));
        last_row = row_ext >= (h_eff - EHW'(1));
        row_ge1  = r_row != '0;
        col_ge1  = r_col != '0;
        interior = (r_row >= RW'(2)) && (r_col >= CW'(2))
                && (col_ext <= (w_eff - EWW'(1))) && (row_ext <= (h_eff - EHW'(1)));
        n_meta.mask[SLOT_INNER]  = row_ge1 && col_ge1;
        n_meta.mask[SLOT_RIGHT]  = row_ge1 && last_col;
        n_meta.mask[SLOT_BOTTOM] = row_ge1 && last_row && col_ge1;
        n_meta.mask[SLOT_CORNER] = row_ge1 && last_row && last_col;
        n_meta.border0 = !interior;
        n_meta.row_a   = 10'(r_row - RW'(1));
        n_meta.row_b   = 10'(r_row);
        n_meta.col_a   = 9'(r_col - CW'(1));
        n_meta.col_b   = 9'(r_col);
    end

    // Advance the raster position; wrap to the next row, and to row zero after the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Line memory: {upper row, middle row} per column. Read at accept,
    // written back when the item moves on. Consecutive items always
    // address different columns and a column comes back no sooner than
    // three items later, so no forwarding is needed.
    // ---------------------------------------------------------------
    logic [47:0]   line_mem [MAX_COLS];
    logic [47:0]   r_rd_data;
    logic [CW-1:0] r_s1_col;
    t_pix          r_s1_cur;
    t_meta         r_s1_meta;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= line_mem[r_col];
        end
        if (adv1) begin
            // upper takes the old middle, middle takes the current pixel
            line_mem[r_s1_col] <= {r_rd_data[23:0], r_s1_cur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept || (r_s1_valid && !adv1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col  <= r_col;
            r_s1_cur  <= {i_blue_in, i_green_in, i_red_in};
            r_s1_meta <= n_meta;
        end
    end

    // ---------------------------------------------------------------
    // 3x3 window: shift left one column, load the new right column
    // ---------------------------------------------------------------
    t_win  r_win;
    t_meta r_s2_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_win[0]    <= r_win[1];
                r_win[1]    <= r_win[2];
                r_win[2][0] <= r_rd_data[47:24];
                r_win[2][1] <= r_rd_data[23:0];
                r_win[2][2] <= r_s1_cur;
            end
            r_s2_valid <= adv1 || (r_s2_valid && !adv2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s2_meta <= r_s1_meta;
        end
    end

    // ---------------------------------------------------------------
    // Sharpen arithmetic and pass-through candidates
    // ---------------------------------------------------------------
    t_pix       sharp_pix;
    t_meta      r_s3_meta;
    t_pix [3:0] r_s3_pix;
    t_bundle    bundle;

    shp_kernel u_kernel (
        .i_clk (i_clk),
        .i_en  (adv2),
        .i_k   (r_strength_k),
        .i_win (r_win),
        .o_pix (sharp_pix)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= adv2 || (r_s3_valid && !adv3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s3_meta              <= r_s2_meta;
            r_s3_pix[SLOT_INNER]   <= r_win[1][1];
            r_s3_pix[SLOT_RIGHT]   <= r_win[2][1];
            r_s3_pix[SLOT_BOTTOM]  <= r_win[1][2];
            r_s3_pix[SLOT_CORNER]  <= r_win[2][2];
        end
    end

    // Border pixels keep the raw value, interior ones take the filtered value
    always_comb begin
        bundle.meta = r_s3_meta;
        bundle.pix  = r_s3_pix;
        if (!r_s3_meta.border0) begin
            bundle.pix[SLOT_INNER] = sharp_pix;
        end
    end

    shp_drain u_drain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s3_valid),
        .i_bundle      (bundle),
        .o_take        (drain_take),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_is_border   (o_is_border),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `SHP_ASSERT_IMPLY(a_mem_no_collide, i_clk, i_rst_n, adv1 && in_accept, r_s1_col != r_col)
    `SHP_ASSERT_IMPLY(a_done_is_last, i_clk, i_rst_n, o_out_valid && o_frame_done, o_last_of_run && o_is_border)
    `SHP_ASSERT_IMPLY(a_interior_pos, i_clk, i_rst_n, o_out_valid && !o_is_border, o_out_row != 10'd0 && o_out_col != 9'd0)
    `SHP_ASSERT_NEXT(a_s3_hold, i_clk, i_rst_n, r_s3_valid && !adv3, r_s3_valid && $stable(r_s3_meta))

endmodule

FILE: bench/tb_sharpen_3x3_rgb_stream.sv
// Self-checking bench for the 3x3 RGB sharpen stream: table frames, random frames, live predictor.
module tb_sharpen_3x3_rgb_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import shp_pkg::*;

    // Index past the register list; the block must ignore writes to it
    localparam logic [1:0] REG_NONE = 2'd3;

    localparam int          RAND_ITEMS   = 440;
    localparam int          DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] row;
        logic [8:0] col;
        logic       border;
        logic       last_run;
        logic       done;
    } t_sharp_px;

    typedef enum logic [1:0] {ROW_PIX, ROW_PIX_CHK, ROW_CFG} t_row_kind;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum int {STY_NOISE, STY_SAT, STY_SMOOTH} t_pix_style;

    typedef struct packed {
        t_row_kind             kind;
        logic [1:0]            idx;
        logic [CFG_DATA_W-1:0] data;
        t_pix                  px;
        t_sharp_px             want;    // first result of the beat, ROW_PIX_CHK only
    } t_dir_row;

    // Pixels are {blue, green, red}. The ring is red 0, green 255, blue 128; the
    // center flips red and green, so one interior pixel saturates high in red,
    // low in green and passes blue through unchanged at strength 4.
    localparam t_pix RING   = 24'h80FF00;
    localparam t_pix CENTER = 24'h8000FF;
    localparam t_sharp_px RING_TOP_LEFT =
        '{8'h00, 8'hFF, 8'h80, 10'd0, 9'd0, 1'b1, 1'b1, 1'b0};
    localparam t_sharp_px SHARP_MIDDLE =
        '{8'hFF, 8'h00, 8'h80, 10'd1, 9'd1, 1'b0, 1'b0, 1'b0};

    localparam int DIR_N = 26;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        // 3x3 frame at reset strength; bit 10 of the width write is dropped
        '{ROW_CFG,     REG_IMAGE_WIDTH,  11'h403, 24'h0,    '0},
        '{ROW_CFG,     REG_IMAGE_HEIGHT, 11'd1,   24'h0,    '0},    // clamps up to 3
        '{ROW_CFG,     REG_NONE,         11'h7FF, 24'h0,    '0},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX_CHK, '0,               '0,      CENTER,   RING_TOP_LEFT},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX,     '0,               '0,      RING,     '0},
        '{ROW_PIX_CHK, '0,               '0,      RING,     SHARP_MIDDLE},
        // 4x3 frame at full strength; upper data bits of the strength write drop
        '{ROW_CFG,     REG_STRENGTH_K,   11'h7FF, 24'h0,    '0},
        '{ROW_CFG,     REG_IMAGE_WIDTH,  11'd4,   24'h0,    '0},
        '{ROW_PIX,     '0,               '0,      24'h000000, '0},
        '{ROW_PIX,     '0,               '0,      24'hFFFFFF, '0},
        '{ROW_PIX,     '0,               '0,      24'h000000, '0},
        '{ROW_PIX,     '0,               '0,      24'hFF00FF, '0},
        '{ROW_PIX,     '0,               '0,      24'hFFFFFF, '0},
        '{ROW_PIX,     '0,               '0,      24'h0000FF, '0},
        '{ROW_PIX,     '0,               '0,      24'h123456, '0},
        '{ROW_PIX,     '0,               '0,      24'hFFFFFF, '0},
        '{ROW_PIX,     '0,               '0,      24'h00FF00, '0},
        '{ROW_PIX,     '0,               '0,      24'hA5A5A5, '0},
        '{ROW_PIX,     '0,               '0,      24'h5A5A5A, '0},
        '{ROW_PIX,     '0,               '0,      24'h000000, '0}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [1:0]            i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_red_in   = '0;
    logic [7:0]            i_green_in = '0;
    logic [7:0]            i_blue_in  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_red_out;
    logic [7:0]            o_green_out;
    logic [7:0]            o_blue_out;
    logic [9:0]            o_out_row;
    logic [8:0]            o_out_col;
    logic                  o_is_border;
    logic                  o_last_of_run;
    logic                  o_frame_done;

    // Predictor state: line memories, window, raster position and registers
    t_pix        upper_ln  [SHP_MAX_COLS];
    t_pix        middle_ln [SHP_MAX_COLS];
    t_win        win;
    int unsigned row_cnt;
    int unsigned col_cnt;
    logic [3:0]  k_reg;
    logic [9:0]  w_reg;
    logic [10:0] h_reg;

    t_sharp_px   px_due [$];     // sharpened pixels the block still owes
    t_sharp_px   due_px;
    t_pix        pix_base;
    int          send_gap_pct  = 0;
    int          out_stall_pct = 0;
    int          mismatches    = 0;
    int unsigned cycles        = 0;

    sharpen_3x3_rgb_stream u_dut (.*);

    always #1 i_clk = ~i_clk;

    // Give up on a hung block
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < out_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s of pixel (%0d,%0d)", name, due_px.row, due_px.col),
                            got, want);
    endtask

    // Compare every accepted result beat against the oldest owed pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (px_due.size() == 0) begin
                report_mismatch("result beat with nothing owed", longint'({o_out_row, o_out_col}),
                                0);
            end else begin
                due_px = px_due.pop_front();
                check_field("red",         o_red_out,     due_px.red);
                check_field("green",       o_green_out,   due_px.green);
                check_field("blue",        o_blue_out,    due_px.blue);
                check_field("row",         o_out_row,     due_px.row);
                check_field("col",         o_out_col,     due_px.col);
                check_field("border",      o_is_border,   due_px.border);
                check_field("last of run", o_last_of_run, due_px.last_run);
                check_field("frame done",  o_frame_done,  due_px.done);
            end
        end
    end

    function automatic int unsigned eff_w();
        if (w_reg < SIZE_MIN) return SIZE_MIN;
        if (w_reg > SHP_MAX_COLS) return SHP_MAX_COLS;
        return int'(w_reg);
    endfunction

    // Pass the pixel through on a border, else apply the 3x3 kernel per channel:
    // 8(K+1)*center - K*neighbors, floored to eighths and clamped to a byte.
    function automatic t_sharp_px sharp_px(input t_pix px, input int unsigned r,
                                           input int unsigned c, input bit border,
                                           input bit done);
        t_sharp_px res;
        int        ch, a, b, k, center, sum, v;
        k = int'(k_reg);
        for (ch = 0; ch < 3; ch++) begin
            if (border) begin
                v = int'(px[8*ch +: 8]);
            end else begin
                center = int'(win[1][1][8*ch +: 8]);
                sum = -center;
                for (a = 0; a < 3; a++)
                    for (b = 0; b < 3; b++)
                        sum += int'(win[a][b][8*ch +: 8]);
                v = 8 * (k + 1) * center - k * sum;
                v = (v < 0) ? 0 : v / 8;
                if (v > 255) v = 255;
            end
            case (ch)
                0: res.red = 8'(v);
                1: res.green = 8'(v);
                default: res.blue = 8'(v);
            endcase
        end
        res.row      = 10'(r);
        res.col      = 9'(c);
        res.border   = border;
        res.last_run = 1'b0;
        res.done     = done;
        return res;
    endfunction

    // Advance the predictor by one accepted pixel and queue what it owes
    function automatic void absorb_pixel(input t_pix cur);
        int unsigned w, h, row, col, idx;
        bit          last_col, last_row, interior;
        t_pix        up, mid;
        t_sharp_px   res [4];
        int          n, a;
        w = eff_w();
        h = (h_reg < SIZE_MIN) ? SIZE_MIN : (h_reg > SHP_MAX_ROWS) ? SHP_MAX_ROWS : int'(h_reg);
        row = row_cnt;
        col = col_cnt;
        // A position at or past a shrunken bound counts as the last one
        last_col = col >= w - 1;
        last_row = row >= h - 1;
        idx = col % SHP_MAX_COLS;
        up  = upper_ln[idx];
        mid = middle_ln[idx];
        upper_ln[idx]  = mid;
        middle_ln[idx] = cur;
        for (a = 0; a < 3; a++) begin
            win[0][a] = win[1][a];
            win[1][a] = win[2][a];
        end
        win[2][0] = up;
        win[2][1] = mid;
        win[2][2] = cur;

        n = 0;
        if (row >= 1) begin
            if (col >= 1) begin
                interior = row >= 2 && col >= 2 && col <= w - 1 && row <= h - 1;
                res[n] = sharp_px(win[1][1], row - 1, col - 1, !interior, 1'b0);
                n++;
            end
            // Flush the right border pixel of the row above
            if (last_col) begin
                res[n] = sharp_px(win[2][1], row - 1, col, 1'b1, 1'b0);
                n++;
            end
            // Flush the bottom row; its corner closes the frame
            if (last_row) begin
                if (col >= 1) begin
                    res[n] = sharp_px(win[1][2], row, col - 1, 1'b1, 1'b0);
                    n++;
                end
                if (last_col) begin
                    res[n] = sharp_px(win[2][2], row, col, 1'b1, 1'b1);
                    n++;
                end
            end
        end
        if (n > 0) res[n-1].last_run = 1'b1;
        for (a = 0; a < n; a++) px_due.push_back(res[a]);

        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : row + 1;
        end else begin
            col_cnt = col + 1;
        end
    endfunction

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_gap_pct = 0;  out_stall_pct = 0;  end
            IDLE_SEND: begin send_gap_pct = 61; out_stall_pct = 0;  end
            IDLE_RECV: begin send_gap_pct = 0;  out_stall_pct = 61; end
            default:   begin send_gap_pct = 15; out_stall_pct = 15; end
        endcase
    endtask

    // Drop valid and hold off until every owed beat is out and the pipe is empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        i_cfg_we   <= 1'b0;
        while (px_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Hold the write for one edge; the next driving step lowers the enable
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_STRENGTH_K:   k_reg = data[3:0];
            REG_IMAGE_WIDTH:  w_reg = data[9:0];
            REG_IMAGE_HEIGHT: h_reg = data;
            default: ;
        endcase
    endtask

    // Present one pixel beat, hold it through stalls, predict on acceptance
    task automatic push_pixel(input t_pix px, output int first);
        while ($urandom_range(99) < send_gap_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_cfg_we   <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_cfg_we   <= 1'b0;
        i_red_in   <= px[7:0];
        i_green_in <= px[15:8];
        i_blue_in  <= px[23:16];
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        first = px_due.size();
        absorb_pixel(px);
    endtask

    // Stream one frame. At row ends, now and then pause and change strength or
    // shrink the width; on cut_rows, shrink the height so the frame ends there.
    // On cut_col, shrink the width in row zero so that row ends at that column.
    task automatic feed_frame(input t_pix_style style, input int cut_rows, input int cut_col,
                              output int fed);
        int   first, ch;
        t_pix px;
        fed = 0;
        pix_base = {8'($urandom_range(240)), 8'($urandom_range(240)), 8'($urandom_range(240))};
        do begin
            case (style)
                STY_NOISE: px = 24'($urandom);
                STY_SAT:
                    for (ch = 0; ch < 3; ch++)
                        px[8*ch +: 8] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                default:
                    for (ch = 0; ch < 3; ch++)
                        px[8*ch +: 8] = pix_base[8*ch +: 8] + 8'($urandom_range(15));
            endcase
            push_pixel(px, first);
            fed++;
            if (cut_col != 0 && row_cnt == 0 && col_cnt == cut_col) begin
                // Every column below the new width was already written in this row
                settle();
                write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(SIZE_MIN, cut_col)));
            end
            if (col_cnt == 0 && row_cnt != 0) begin
                if (cut_rows != 0 && row_cnt == cut_rows) begin
                    settle();
                    write_reg(REG_IMAGE_HEIGHT, 11'($urandom_range(2)));
                end else if ($urandom_range(7) == 0) begin
                    settle();
                    write_reg(REG_STRENGTH_K, 11'($urandom));
                end else if (row_cnt >= 2 && $urandom_range(9) == 0) begin
                    // Never widen mid-frame: that would read unwritten line memory
                    settle();
                    write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(SIZE_MIN, eff_w())));
                end
            end
        end while (row_cnt != 0 || col_cnt != 0);
    endtask

    initial begin
        int i, first, fed, phase, normal_items, wraw, hraw;

        foreach (upper_ln[j]) begin
            upper_ln[j]  = '0;
            middle_ln[j] = '0;
        end
        win     = '0;
        row_cnt = 0;
        col_cnt = 0;
        k_reg   = STRENGTH_RST;
        w_reg   = WIDTH_RST;
        h_reg   = HEIGHT_RST;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames: walk the table, cross-check the typed results
        set_idling(IDLE_NONE);
        for (i = 0; i < DIR_N; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG) begin
                settle();
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].data);
            end else begin
                push_pixel(DIR_TAB[i].px, first);
                if (DIR_TAB[i].kind == ROW_PIX_CHK &&
                    (px_due.size() <= first || px_due[first] != DIR_TAB[i].want))
                    report_mismatch($sformatf("typed result of table row %0d", i),
                                    longint'(px_due[first]), longint'(DIR_TAB[i].want));
            end
        end

        // Random frames, one idling mode per frame; configure between frames and at feed_frame's cuts
        phase = 0;
        normal_items = 0;
        while (normal_items < RAND_ITEMS) begin
            set_idling(t_idle_mode'(phase % 4));
            settle();
            if (phase == 2) begin
                // Width above the maximum, row zero cut short by a narrower width;
                // identity strength
                write_reg(REG_STRENGTH_K, {7'($urandom), 4'd0});
                write_reg(REG_IMAGE_WIDTH, {1'($urandom), 10'h3FF});
                write_reg(REG_IMAGE_HEIGHT, 11'd3);
                feed_frame(t_pix_style'($urandom_range(2)), 0, $urandom_range(20, 40), fed);
            end else if (phase == 5) begin
                // Tallest setting: height clamps to the maximum, then is cut short
                write_reg(REG_STRENGTH_K, 11'($urandom));
                write_reg(REG_IMAGE_WIDTH, 11'($urandom_range(3, 6)));
                write_reg(REG_IMAGE_HEIGHT, 11'h7FF);
                feed_frame(t_pix_style'($urandom_range(2)), 5, 0, fed);
            end else begin
                wraw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
                hraw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 7);
                write_reg(REG_STRENGTH_K, 11'($urandom));
                write_reg(REG_IMAGE_WIDTH, {1'($urandom), 10'(wraw)});
                write_reg(REG_IMAGE_HEIGHT, 11'(hraw));
                if ($urandom_range(3) == 0) write_reg(REG_NONE, 11'($urandom));
                feed_frame(t_pix_style'($urandom_range(2)), 0, 0, fed);
            end
            normal_items += fed;
            phase++;
        end

        settle();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/shp_pkg.sv
hdl/shp_kernel.sv
hdl/shp_drain.sv
hdl/sharpen_3x3_rgb_stream.sv
bench/tb_sharpen_3x3_rgb_stream.sv
